[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define SSPQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check an implication in the cycle after the antecedent, outside reset.
`define SSPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Check a plain condition on every clock edge outside reset.
`define SSPQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

[src/sspq_pkg.sv]
// Shared constants and types of the stable sorted priority queue.
`default_nettype none

package sspq_pkg;

  // Field widths fixed by the stream format
  localparam int PRI_BITS = 16;
  localparam int TAG_BITS = 16;

  // Defaults of the top-level parameters
  localparam int DEPTH_DEF        = 16;
  localparam int PAYLOAD_BITS_DEF = 16;

  // Operation codes carried in tuser
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic enq;
    logic deq;
  } sspq_cmd_t;

endpackage

`default_nettype wire

[src/stable_sorted_priority_queue_unit.sv]
// Top level of the stable sorted priority queue: row of cells, count and result beat.
`default_nettype none
`include "assert_macros.svh"

// Stable minimum priority queue of DEPTH entries held in a row of cells, kept in
// ascending signed priority; equal priorities leave in arrival order. Each input
// beat is an enqueue (tuser = 0) or a dequeue of the head (tuser = 1); every beat
// returns one result beat with the head entry, a head valid bit, the entry count
// after the operation and a drop flag for an enqueue into a full queue. A dequeue
// of an empty queue changes nothing. On each accepted beat all cells compare the
// new priority in parallel and shift at the same clock edge, and the result is
// read from the head cell in the cycle after. One beat per cycle is sustained as
// long as the result side takes a beat every cycle. Only the low PAYLOAD_BITS bits
// of a payload are stored.
module stable_sorted_priority_queue_unit #(
  parameter int DEPTH        = sspq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_BITS = sspq_pkg::PAYLOAD_BITS_DEF,
  localparam int CntW        = $clog2(DEPTH + 1),
  localparam int OutBits     = 2 + 2 * sspq_pkg::PRI_BITS + CntW,
  localparam int OutW        = ((OutBits + 7) / 8) * 8
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                s_axis_tvalid,
  output logic               s_axis_tready,
  // priority_req [15:0], payload [31:16]
  input  wire  [31:0]        s_axis_tdata,
  // func [0]
  input  wire  [0:0]         s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire                m_axis_tready,
  // head_valid [0], head_priority [16:1], head_payload [32:17],
  // entry_count [33 +: CntW], dropped [33 + CntW], zero fill above
  output logic [OutW-1:0]    m_axis_tdata
);

  localparam int PriW   = sspq_pkg::PRI_BITS;
  localparam int TagW   = sspq_pkg::TAG_BITS;
  localparam int WideW  = (PAYLOAD_BITS > TagW) ? PAYLOAD_BITS : TagW;

  // Handshakes
  logic in_acc, out_acc;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Unpack the input beat
  logic signed [PriW-1:0]   in_pri;
  logic [TagW-1:0]          in_tag;
  logic [WideW-1:0]         in_tag_wide;
  logic [PAYLOAD_BITS-1:0]  in_pl;
  assign in_pri      = s_axis_tdata[PriW-1:0];
  assign in_tag      = s_axis_tdata[PriW +: TagW];
  assign in_tag_wide = WideW'(in_tag);
  assign in_pl       = in_tag_wide[PAYLOAD_BITS-1:0];

  // Decode the operation against the fill level
  logic [CntW-1:0]     count, count_next;
  logic                full, empty;
  sspq_pkg::sspq_cmd_t cmd;
  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign cmd.enq = in_acc && (s_axis_tuser[0] == sspq_pkg::FUNC_ENQ) && !full;
  assign cmd.deq = in_acc && (s_axis_tuser[0] == sspq_pkg::FUNC_DEQ) && !empty;

  // Row of cells
  logic                    cell_lt    [DEPTH];
  logic                    cell_valid [DEPTH];
  logic signed [PriW-1:0]  cell_pri   [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_pl    [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    p_lt, p_valid, n_valid;
    logic signed [PriW-1:0]  p_pri, n_pri;
    logic [PAYLOAD_BITS-1:0] p_pl, n_pl;

    if (i == 0) begin : g_first
      assign p_lt    = 1'b0;
      assign p_valid = 1'b0;
      assign p_pri   = '0;
      assign p_pl    = '0;
    end else begin : g_mid
      assign p_lt    = cell_lt[i-1];
      assign p_valid = cell_valid[i-1];
      assign p_pri   = cell_pri[i-1];
      assign p_pl    = cell_pl[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_pri   = '0;
      assign n_pl    = '0;
    end else begin : g_inner
      assign n_valid = cell_valid[i+1];
      assign n_pri   = cell_pri[i+1];
      assign n_pl    = cell_pl[i+1];
    end

    sspq_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .new_pri   (in_pri),
      .new_pl    (in_pl),
      .prev_lt   (p_lt),
      .prev_valid(p_valid),
      .prev_pri  (p_pri),
      .prev_pl   (p_pl),
      .next_valid(n_valid),
      .next_pri  (n_pri),
      .next_pl   (n_pl),
      .lt        (cell_lt[i]),
      .valid     (cell_valid[i]),
      .pri       (cell_pri[i]),
      .pl        (cell_pl[i])
    );
  end

  // Track the number of stored entries
  always_comb begin
    count_next = count;
    if (cmd.enq) begin
      count_next = count + CntW'(1);
    end else if (cmd.deq) begin
      count_next = count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Hold the result beat until taken; flag a refused enqueue
  logic dropped;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      dropped       <= 1'b0;
    end else if (in_acc) begin
      m_axis_tvalid <= 1'b1;
      dropped       <= (s_axis_tuser[0] == sspq_pkg::FUNC_ENQ) && full;
    end else if (out_acc) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Read the head cell, zero when the queue is empty
  logic                   head_valid;
  logic signed [PriW-1:0] head_pri;
  logic [WideW-1:0]       head_pl_wide;
  logic [TagW-1:0]        head_tag;
  assign head_valid   = cell_valid[0];
  assign head_pri     = head_valid ? cell_pri[0] : '0;
  assign head_pl_wide = head_valid ? WideW'(cell_pl[0]) : '0;
  assign head_tag     = head_pl_wide[TagW-1:0];

  // Pack the result beat
  assign m_axis_tdata = OutW'({dropped, count, head_tag, head_pri, head_valid});

  // Checks on the queue bookkeeping
  `SSPQ_ASSERT_ALWAYS(a_count_range, count <= CntW'(DEPTH), "entry count above depth")
  `SSPQ_ASSERT_ALWAYS(a_head_matches_count, head_valid == (count != '0),
                      "head cell validity disagrees with entry count")
  `SSPQ_ASSERT_NEXT(a_enq_grows, cmd.enq, count == $past(count) + CntW'(1),
                    "accepted enqueue did not grow the queue")
  `SSPQ_ASSERT_IMPL(a_drop_only_full, m_axis_tvalid && dropped, full,
                    "drop reported while queue not full")

endmodule

`default_nettype wire

[src/sspq_cell.sv]
// One slot of the sorted row: holds an entry and trades it with its neighbors.
`default_nettype none

module sspq_cell #(
  parameter int PAYLOAD_BITS = sspq_pkg::PAYLOAD_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire sspq_pkg::sspq_cmd_t             cmd,
  input  wire logic signed [sspq_pkg::PRI_BITS-1:0] new_pri,
  input  wire logic [PAYLOAD_BITS-1:0]         new_pl,
  // left neighbor (closer to the head)
  input  wire logic                            prev_lt,
  input  wire logic                            prev_valid,
  input  wire logic signed [sspq_pkg::PRI_BITS-1:0] prev_pri,
  input  wire logic [PAYLOAD_BITS-1:0]         prev_pl,
  // right neighbor (closer to the tail)
  input  wire logic                            next_valid,
  input  wire logic signed [sspq_pkg::PRI_BITS-1:0] next_pri,
  input  wire logic [PAYLOAD_BITS-1:0]         next_pl,
  // own contents
  output logic                                 lt,
  output logic                                 valid,
  output logic signed [sspq_pkg::PRI_BITS-1:0] pri,
  output logic [PAYLOAD_BITS-1:0]              pl
);

  // New entry goes in front of this slot when the slot is empty or strictly larger
  assign lt = !valid || (new_pri < pri);

  // Valid bit: take the new entry, shift right, or shift left
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.enq && lt) begin
      valid <= prev_lt ? prev_valid : 1'b1;
    end else if (cmd.deq) begin
      valid <= next_valid;
    end
  end

  // Entry contents follow the same moves
  always_ff @(posedge clk) begin
    if (cmd.enq && lt) begin
      if (prev_lt) begin
        pri <= prev_pri;
        pl  <= prev_pl;
      end else begin
        pri <= new_pri;
        pl  <= new_pl;
      end
    end else if (cmd.deq) begin
      pri <= next_pri;
      pl  <= next_pl;
    end
  end

endmodule

`default_nettype wire

[verif/sspq_order_checker.sv]
// Result checker for the stable sorted priority queue: predicts the head beats and compares them.
`timescale 1ns / 1ps

module sspq_order_checker #(
  parameter int DEPTH = sspq_pkg::DEPTH_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  input  wire        s_axis_tready,
  // priority_req [15:0], payload [31:16]
  input  wire [31:0] s_axis_tdata,
  // func [0]
  input  wire [0:0]  s_axis_tuser,
  input  wire        m_axis_tvalid,
  input  wire        m_axis_tready,
  // head_valid [0], head_priority [16:1], head_payload [32:17],
  // entry_count [37:33], dropped [38], zero fill above
  input  wire [39:0] m_axis_tdata,
  output int         fail_count,
  output int         outstanding
);

  localparam int CntW = $clog2(DEPTH + 1);

  // One result beat, fields declared from the highest bit down to bit 0
  typedef struct packed {
    logic                                dropped;
    logic [CntW-1:0]                     entry_count;
    logic [sspq_pkg::TAG_BITS-1:0]       head_payload;
    logic signed [sspq_pkg::PRI_BITS-1:0] head_priority;
    logic                                head_valid;
  } head_beat_t;

  // Own copy of the sorted row
  logic signed [sspq_pkg::PRI_BITS-1:0] row_pri [DEPTH];
  logic [sspq_pkg::TAG_BITS-1:0]        row_tag [DEPTH];
  int                                   row_len;

  head_beat_t expected_heads [$];
  int         mismatch_total;

  initial begin
    fail_count     = 0;
    outstanding    = 0;
    row_len        = 0;
    mismatch_total = 0;
  end

  // Apply one enqueue or dequeue to the row and return the head beat it yields
  function automatic head_beat_t apply_queue_op(
    input logic                                op,
    input logic signed [sspq_pkg::PRI_BITS-1:0] pri,
    input logic [sspq_pkg::TAG_BITS-1:0]       tag
  );
    head_beat_t beat;
    int         slot;
    beat = '0;
    if (op == sspq_pkg::FUNC_ENQ) begin
      if (row_len >= DEPTH) begin
        beat.dropped = 1'b1;
      end else begin
        // insert after every entry of lower or equal priority
        slot = 0;
        while (slot < row_len && row_pri[slot] <= pri) slot++;
        for (int i = row_len; i > slot; i--) begin
          row_pri[i] = row_pri[i-1];
          row_tag[i] = row_tag[i-1];
        end
        row_pri[slot] = pri;
        row_tag[slot] = tag;
        row_len++;
      end
    end else if (row_len > 0) begin
      // drop the head, shift the rest up
      for (int i = 1; i < row_len; i++) begin
        row_pri[i-1] = row_pri[i];
        row_tag[i-1] = row_tag[i];
      end
      row_len--;
    end
    if (row_len > 0) begin
      beat.head_valid    = 1'b1;
      beat.head_priority = row_pri[0];
      beat.head_payload  = row_tag[0];
    end
    beat.entry_count = CntW'(row_len);
    return beat;
  endfunction

  // Count a failure, report only the first few
  task automatic report_failure(input string what, input head_beat_t want, input head_beat_t got);
    if (mismatch_total < 10)
      $display("%0t: %s exp v=%0b pri=%0d tag=%h cnt=%0d drop=%0b act v=%0b pri=%0d tag=%h cnt=%0d drop=%0b",
               $time, what, want.head_valid, want.head_priority, want.head_payload,
               want.entry_count, want.dropped, got.head_valid, got.head_priority,
               got.head_payload, got.entry_count, got.dropped);
    mismatch_total++;
  endtask

  // Predict on each accepted input beat, compare on each accepted result beat
  always @(posedge clk) begin
    head_beat_t want;
    head_beat_t got;
    if (rst) begin
      row_len = 0;
      expected_heads.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_heads.insert(expected_heads.size(),
                              apply_queue_op(s_axis_tuser[0], s_axis_tdata[15:0],
                                             s_axis_tdata[31:16]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.head_valid    = m_axis_tdata[0];
        got.head_priority = m_axis_tdata[16:1];
        got.head_payload  = m_axis_tdata[32:17];
        got.entry_count   = m_axis_tdata[33 +: CntW];
        got.dropped       = m_axis_tdata[33 + CntW];
        if (expected_heads.size() == 0) begin
          report_failure("unexpected result beat", '0, got);
        end else begin
          want = expected_heads.pop_front();
          if (got.head_valid !== want.head_valid ||
              got.head_priority !== want.head_priority ||
              got.head_payload !== want.head_payload ||
              got.entry_count !== want.entry_count ||
              got.dropped !== want.dropped)
            report_failure("head mismatch", want, got);
        end
      end
    end
    outstanding <= expected_heads.size();
    fail_count  <= mismatch_total;
  end

endmodule

[verif/tb_top.sv]
// Testbench top for the stable sorted priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  int fail_count;
  int outstanding;
  int tx_idle_pct = 6;
  int rx_idle_pct = 58;

  stable_sorted_priority_queue_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sspq_order_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Hand over one operation beat, with an optional gap first, and wait until it is taken
  task automatic send_op(input logic op, input logic signed [15:0] pri, input logic [15:0] tag);
    int gap;
    @(negedge clk);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tag, pri};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Hold the input side until every expected head beat has come back
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Mix of full-range, clustered (ties) and extreme priorities
  function automatic logic signed [15:0] pick_priority();
    int v;
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(0, 6) - 3;
      1: begin
        case ($urandom_range(0, 3))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = -1;
          default: v = 0;
        endcase
      end
      default: v = $urandom_range(0, 65535);
    endcase
    return v[15:0];
  endfunction

  // Random episodes that lean toward filling, draining or neither
  task automatic run_random(input int count);
    int sent;
    int enq_pct;
    int run_len;
    logic op;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 2))
        0:       enq_pct = 85;
        1:       enq_pct = 15;
        default: enq_pct = 50;
      endcase
      run_len = $urandom_range(8, 40);
      for (int i = 0; i < run_len && sent < count; i++) begin
        op = ($urandom_range(0, 99) < enq_pct) ? sspq_pkg::FUNC_ENQ : sspq_pkg::FUNC_DEQ;
        send_op(op, pick_priority(), 16'($urandom_range(0, 65535)));
        sent++;
      end
      if ($urandom_range(0, 99) < 5) drain_results();
    end
  endtask

  // Reset, directed beats, three random phases, verdict
  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // dequeue of an empty queue
    send_op(sspq_pkg::FUNC_DEQ, 16'sh0000, 16'hFFFF);
    // extremes and ties, including ties at both ends of the range
    send_op(sspq_pkg::FUNC_ENQ, 16'sh7FFF, 16'hFFFF);
    send_op(sspq_pkg::FUNC_ENQ, 16'sh8000, 16'h0000);
    send_op(sspq_pkg::FUNC_ENQ, 16'sh0000, 16'hAAAA);
    send_op(sspq_pkg::FUNC_ENQ, 16'sh0000, 16'h5555);
    send_op(sspq_pkg::FUNC_ENQ, 16'sh8000, 16'h0001);
    send_op(sspq_pkg::FUNC_ENQ, 16'sh7FFF, 16'h0002);
    // fill to the top
    for (int i = 0; i < 10; i++)
      send_op(sspq_pkg::FUNC_ENQ, 16'(i - 4), 16'(16'h0100 + i));
    // enqueue into a full queue, once at the lowest and once at the highest priority
    send_op(sspq_pkg::FUNC_ENQ, 16'sh8000, 16'hDEAD);
    send_op(sspq_pkg::FUNC_ENQ, 16'sh7FFF, 16'hBEEF);
    repeat (4) send_op(sspq_pkg::FUNC_DEQ, 16'sh1234, 16'h4321);

    run_random(560);
    drain_results();

    tx_idle_pct = 58;
    rx_idle_pct = 6;
    run_random(560);
    drain_results();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(560);
    drain_results();

    repeat (20) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Give up on a hang
  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

[stable_sorted_priority_queue_unit.f]
+incdir+src
src/sspq_pkg.sv
src/sspq_cell.sv
src/stable_sorted_priority_queue_unit.sv
verif/sspq_order_checker.sv
verif/tb_top.sv
